### rtl/sefm_pkg.sv
// Shared types, codes and constants of the sensor EMA fault monitor.
package sefm_pkg;

	localparam int unsigned MV_W     = 16;
	localparam int unsigned ALPHA_W  = 17;
	localparam int unsigned LIMIT_W  = 8;
	localparam int unsigned FILT_W   = 32;
	localparam int unsigned FRAC_W   = 16;
	localparam int unsigned OPC_W    = 3;
	localparam int unsigned STAT_W   = 2;
	localparam int unsigned CIDX_W   = 2;
	localparam int unsigned CDATA_W  = 17;
	localparam int unsigned S_DATA_W = 24;
	localparam int unsigned M_DATA_W = 24;

	localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 17'h10000;
	localparam logic [ALPHA_W-1:0] ALPHA_RST   = 17'd6554;
	localparam logic [MV_W-1:0]    MIN_MV_RST  = 16'd100;
	localparam logic [MV_W-1:0]    MAX_MV_RST  = 16'd3200;
	localparam logic [LIMIT_W-1:0] MAX_FAIL_RST = 8'd3;

	typedef enum logic [OPC_W-1:0] {
		OP_INIT  = 3'd0,
		OP_POLL  = 3'd1,
		OP_START = 3'd2,
		OP_STOP  = 3'd3,
		OP_RESET = 3'd4
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK       = 2'd0,
		ST_FAIL     = 2'd1,
		ST_NOT_INIT = 2'd2,
		ST_REFUSED  = 2'd3
	} status_t;

	typedef enum logic [CIDX_W-1:0] {
		CFG_ALPHA    = 2'd0,
		CFG_MIN_MV   = 2'd1,
		CFG_MAX_MV   = 2'd2,
		CFG_MAX_FAIL = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [ALPHA_W-1:0] alpha;
		logic [MV_W-1:0]    min_mv;
		logic [MV_W-1:0]    max_mv;
		logic [LIMIT_W-1:0] max_fail;
	} cfg_t;

	typedef struct packed {
		logic [OPC_W-1:0] opcode;
		logic [MV_W-1:0]  sample_mv;
		logic             converter_ok;
	} item_t;

	typedef struct packed {
		status_t         status;
		logic [MV_W-1:0] filtered_mv;
		logic            filtered_ok;
		logic            healthy;
		logic            active;
		logic            initialized;
	} result_t;

endpackage

### rtl/sefm_cfg.sv
// Configuration register file of the sensor EMA fault monitor.
module sefm_cfg
	import sefm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               we,
	input  logic [CIDX_W-1:0]  idx,
	input  logic [CDATA_W-1:0] wdata,
	output cfg_t               cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.alpha    <= ALPHA_RST;
			cfg_q.min_mv   <= MIN_MV_RST;
			cfg_q.max_mv   <= MAX_MV_RST;
			cfg_q.max_fail <= MAX_FAIL_RST;
		end else if (we) begin
			unique case (cfg_idx_t'(idx))
				CFG_ALPHA:    cfg_q.alpha    <= wdata[ALPHA_W-1:0];
				CFG_MIN_MV:   cfg_q.min_mv   <= wdata[MV_W-1:0];
				CFG_MAX_MV:   cfg_q.max_mv   <= wdata[MV_W-1:0];
				CFG_MAX_FAIL: cfg_q.max_fail <= wdata[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### rtl/sefm_ema.sv
// EMA update y + alpha*(x - y) in unsigned 16.16 millivolts, one multiply.
module sefm_ema
	import sefm_pkg::*;
(
	input  logic [FILT_W-1:0]  y,
	input  logic [MV_W-1:0]    mv,
	input  logic [ALPHA_W-1:0] alpha,
	output logic [FILT_W-1:0]  y_next
);

	localparam int unsigned DIFF_W = FILT_W + 1;
	localparam int unsigned PROD_W = DIFF_W + ALPHA_W + 1;

	logic [ALPHA_W-1:0]       a;
	logic signed [DIFF_W-1:0] diff;
	logic signed [PROD_W-1:0] prod;

	// alpha above one saturates to one
	assign a    = alpha[ALPHA_W-1] ? ALPHA_ONE : alpha;
	assign diff = $signed({1'b0, mv, {FRAC_W{1'b0}}}) - $signed({1'b0, y});
	assign prod = $signed({1'b0, a}) * diff;

	// floor of the signed product over one; the sum stays within 32 bits
	assign y_next = y + prod[FRAC_W+FILT_W-1:FRAC_W];

endmodule

### rtl/sefm_core.sv
// Monitor state, event decode and results; one word per cycle on advance.
module sefm_core
	import sefm_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  item_t   item,
	input  logic    advance,
	output result_t res
);

	logic [FILT_W-1:0]  filt_q, filt_d, ema_y;
	logic [LIMIT_W-1:0] fail_q, fail_d, fail_inc;
	logic               init_q, init_d;
	logic               act_q, act_d;
	logic               hlth_q, hlth_d;
	logic               in_win;
	logic               ok;
	status_t            status;

	sefm_ema u_ema (
		.y      (filt_q),
		.mv     (item.sample_mv),
		.alpha  (cfg.alpha),
		.y_next (ema_y)
	);

	assign in_win   = (item.sample_mv >= cfg.min_mv) && (item.sample_mv <= cfg.max_mv);
	assign fail_inc = (fail_q < cfg.max_fail) ? fail_q + 1'b1 : fail_q;

	always_comb begin
		filt_d = filt_q;
		fail_d = fail_q;
		init_d = init_q;
		act_d  = act_q;
		hlth_d = hlth_q;
		status = ST_OK;
		unique case (op_t'(item.opcode))
			OP_INIT: begin
				if (!init_q) begin
					if (!item.converter_ok) begin
						hlth_d = 1'b0;
						status = ST_FAIL;
					end else begin
						init_d = 1'b1;
						act_d  = 1'b1;
						if (!in_win) begin
							fail_d = 8'd1;
							hlth_d = 1'b0;
							status = ST_FAIL;
						end else begin
							fail_d = '0;
							filt_d = {item.sample_mv, {FRAC_W{1'b0}}};
							hlth_d = 1'b1;
						end
					end
				end
			end
			OP_POLL: begin
				if (!init_q) begin
					status = ST_NOT_INIT;
				end else if (act_q) begin
					if (!in_win) begin
						fail_d = fail_inc;
						if (fail_inc >= cfg.max_fail) begin
							hlth_d = 1'b0;
						end
						status = ST_FAIL;
					end else begin
						fail_d = '0;
						filt_d = ema_y;
						hlth_d = 1'b1;
					end
				end
			end
			OP_START: begin
				if (!init_q) begin
					status = ST_REFUSED;
				end else begin
					act_d = 1'b1;
					if (fail_q < cfg.max_fail) begin
						hlth_d = 1'b1;
					end
				end
			end
			OP_STOP: begin
				if (!init_q) begin
					status = ST_REFUSED;
				end else begin
					act_d = 1'b0;
				end
			end
			OP_RESET: begin
				fail_d = '0;
				filt_d = '0;
				if (!init_q) begin
					hlth_d = 1'b0;
					act_d  = 1'b0;
				end else begin
					hlth_d = 1'b1;
				end
			end
			default: status = ST_REFUSED;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_q <= '0;
			fail_q <= '0;
			init_q <= 1'b0;
			act_q  <= 1'b0;
			hlth_q <= 1'b0;
		end else if (advance) begin
			filt_q <= filt_d;
			fail_q <= fail_d;
			init_q <= init_d;
			act_q  <= act_d;
			hlth_q <= hlth_d;
		end
	end

	assign ok = init_d && act_d && hlth_d;

	always_comb begin
		res.status      = status;
		res.filtered_mv = ok ? filt_d[FILT_W-1:FRAC_W] : '0;
		res.filtered_ok = ok;
		res.healthy     = init_d && hlth_d;
		res.active      = act_d;
		res.initialized = init_d;
	end

endmodule

### rtl/sensor_ema_fault_monitor_unit.sv
// Top level of the sensor EMA fault monitor: input register, core, result register.
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  tuser opcode, tdata sample_mv, converter_ok
//  m_*      out  m_tvalid/m_tready  tdata status .. initialized
//  cfg_*    in   cfg_we             cfg_index, cfg_wdata
//
// One word per cycle sustained while m_tready is high; a word's result passes from
// the input register through the core to the result register and waits for m_tready.
// The filter update (one 18x33 multiply and add) is combinational in the state
// loop. Reset clears the monitor state and loads the register defaults. A stalled
// result holds in the output register; an empty input register takes one more word.
module sensor_ema_fault_monitor_unit
	import sefm_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [OPC_W-1:0]    s_tuser,   // [2:0] opcode
	input  logic [S_DATA_W-1:0] s_tdata,   // [15:0] sample_mv, [16] converter_ok, rest zero
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,   // [1:0] status, [17:2] filtered_mv,
	                                       // [18] filtered_ok, [19] healthy,
	                                       // [20] active, [21] initialized, rest zero
	input  logic                cfg_we,
	input  logic [CIDX_W-1:0]   cfg_index,
	input  logic [CDATA_W-1:0]  cfg_wdata
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    vld_s1;
	result_t res, res_s2;
	logic    vld_s2;
	logic    advance;
	logic    s_take;

	sefm_cfg u_cfg (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (cfg_we),
		.idx   (cfg_index),
		.wdata (cfg_wdata),
		.cfg   (cfg)
	);

	assign advance  = vld_s1 && (!vld_s2 || m_tready);
	assign s_tready = !vld_s1 || advance;
	assign s_take   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_take) begin
			item_s1.opcode       <= s_tuser;
			item_s1.sample_mv    <= s_tdata[MV_W-1:0];
			item_s1.converter_ok <= s_tdata[MV_W];
		end
	end

	sefm_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (item_s1),
		.advance(advance),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (advance) begin
			vld_s2 <= 1'b1;
		end else if (m_tready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = vld_s2;
	assign m_tdata  = {{(M_DATA_W - 22){1'b0}}, res_s2.initialized, res_s2.active,
		res_s2.healthy, res_s2.filtered_ok, res_s2.filtered_mv, res_s2.status};

endmodule

### rtl/sefm_checker.sv
// Port-level checks of the sensor EMA fault monitor, bound to the top level.
module sefm_port_checks
	import sefm_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                s_tvalid,
	input logic                s_tready,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [M_DATA_W-1:0] m_tdata
);

	// a stalled result word holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// a fresh result follows an input word that the input register took
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
		else $error("result word without an input word");

	// usable reading needs all three flags, and no reading is shown otherwise
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[18] ? (m_tdata[19] && m_tdata[20] && m_tdata[21])
			: (m_tdata[17:2] == 16'd0)))
		else $error("filtered reading inconsistent with flags");

	// nothing is offered after an edge seen in reset
	assert property (@(posedge clk) !arst_n |=> !m_tvalid)
		else $error("result offered during reset");

endmodule

bind sensor_ema_fault_monitor_unit sefm_port_checks u_sefm_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
